/* rtl/plel_pkg.sv */
// ----------------------------------------------------------------------------
// plel_pkg: shared types and constants for the positional list engine
// Sizes of the list, request codes, status codes and cell control types.
// ----------------------------------------------------------------------------
package plel_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // fixed field widths of the stream payload
  localparam int CMD_W    = 2;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int FPOS_W   = 6;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 7;
  localparam int IN_W     = CMD_W + POS_W + VAL_W;
  localparam int IN_TW    = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W    = VAL_W + FPOS_W + 1 + STAT_W + LEN_W;
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NO_ELEM   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    CH_IDLE,
    CH_INSERT,
    CH_REMOVE,
    CH_FIND
  } chain_op_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     sample;
    logic     in_list;
  } cell_ctrl_t;

  typedef struct packed {
    chain_op_e              op;
    logic [IDX_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
    logic [VALUE_WIDTH-1:0] key;
  } chain_req_t;

endpackage

/* rtl/plel_cell.sv */
// ----------------------------------------------------------------------------
// plel_cell: one list slot
// Holds one entry, takes a neighbour's entry on a shift and keeps a match
// flag sampled on a find.
// ----------------------------------------------------------------------------
module plel_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  plel_pkg::cell_ctrl_t            ctrl_i,
  input  logic [plel_pkg::VALUE_WIDTH-1:0] left_i,
  input  logic [plel_pkg::VALUE_WIDTH-1:0] right_i,
  input  logic [plel_pkg::VALUE_WIDTH-1:0] key_i,
  output logic [plel_pkg::VALUE_WIDTH-1:0] value_o,
  output logic                            match_o
);
  import plel_pkg::*;

  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   match_q, match_d;

  always_comb begin
    case (ctrl_i.op)
      CELL_LOAD:       value_d = key_i;
      CELL_TAKE_LEFT:  value_d = left_i;
      CELL_TAKE_RIGHT: value_d = right_i;
      default:         value_d = value_q;
    endcase
  end

  // hold the flag until the next find samples it again
  assign match_d = ctrl_i.sample ? (ctrl_i.in_list && (value_q == key_i)) : match_q;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

/* rtl/plel_chain.sv */
// ----------------------------------------------------------------------------
// plel_chain: row of list cells
// Decodes a request into per-cell moves, reads the entry at a position and
// encodes the lowest matching cell.
// ----------------------------------------------------------------------------
module plel_chain (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  plel_pkg::chain_req_t             req_i,
  output logic [plel_pkg::VALUE_WIDTH-1:0] rd_data_o,
  output logic                             found_o,
  output logic [plel_pkg::IDX_W-1:0]       found_pos_o
);
  import plel_pkg::*;

  logic [VALUE_WIDTH-1:0] values [CAPACITY];
  logic [CAPACITY-1:0]    match;
  cell_ctrl_t             ctrl   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_w;
    logic [VALUE_WIDTH-1:0] right_w;

    always_comb begin
      ctrl[i].op      = CELL_HOLD;
      ctrl[i].sample  = (req_i.op == CH_FIND);
      ctrl[i].in_list = (CNT_W'(i) < req_i.count);
      case (req_i.op)
        CH_INSERT: begin
          if (IDX_W'(i) == req_i.pos) begin
            ctrl[i].op = CELL_LOAD;
          end else if (IDX_W'(i) > req_i.pos) begin
            ctrl[i].op = CELL_TAKE_LEFT;
          end
        end
        CH_REMOVE: begin
          if (IDX_W'(i) >= req_i.pos) begin
            ctrl[i].op = CELL_TAKE_RIGHT;
          end
        end
        default: ctrl[i].op = CELL_HOLD;
      endcase
    end

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = values[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = values[i+1];
    end

    plel_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[i]),
      .left_i  (left_w),
      .right_i (right_w),
      .key_i   (req_i.key),
      .value_o (values[i]),
      .match_o (match[i])
    );
  end

  assign rd_data_o = values[req_i.pos];
  assign found_o   = |match;

  // lowest matching slot wins
  always_comb begin
    found_pos_o = '0;
    for (int j = CAPACITY - 1; j >= 0; j--) begin
      if (match[j]) begin
        found_pos_o = IDX_W'(j);
      end
    end
  end

endmodule

/* rtl/positional_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list of signed words with positional
// insert, remove, get and find
// ----------------------------------------------------------------------------
// A request enters on the slave stream (s_axis_*) and names one operation:
// insert before a position, remove at a position, get at a position, or find
// the lowest position holding a value. Each request yields exactly one result
// on the master stream (m_axis_*) with the fetched or removed value, the find
// outcome, a status code and the list length after the operation.
// A failed check (position past the end, no element, list full) sets the
// status and leaves the list untouched.
// Timing: one request at a time; it passes the execute and result states before
// its result is registered, and only then is the next one taken. The cells shift
// or compare every entry at once; the lowest match is encoded from their flags.
// Reset empties the list (length zero) and drops any pending result; entry
// contents are not cleared.
// A stalled receiver holds the result in the output register; the next
// request is still taken and worked on, then waits until the result leaves.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // command[1:0], position[8:2], value[40:9], zero fill above
  input  logic [plel_pkg::IN_TW-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // data_out[31:0], found_position[37:32], found[38], status[40:39],
  // length_now[47:41]
  output logic [plel_pkg::OUT_TW-1:0] m_axis_tdata
);
  import plel_pkg::*;

  state_e                 state_q, state_d;
  logic [CMD_W-1:0]       cmd_q;
  logic [POS_W-1:0]       pos_q;
  logic [VAL_W-1:0]       val_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VAL_W-1:0]       data_q, data_d;
  status_e                status_q, status_d;
  logic                   out_valid_q;
  logic [OUT_TW-1:0]      out_data_q;

  logic                   in_fire;
  logic                   out_free;
  logic                   exec;
  logic                   do_insert;
  logic                   do_remove;
  logic                   do_read;
  chain_req_t             req;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   found;
  logic [IDX_W-1:0]       found_pos;
  logic                   find_hit;
  logic [IDX_W-1:0]       find_pos;
  logic [OUT_W-1:0]       result;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EXEC;
      S_EXEC:  state_d = S_RESP;
      S_RESP:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    exec          = 1'b0;
    case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_EXEC:  exec = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        exec          = 1'b0;
      end
    endcase
  end

  // checks in list order: range first, then full or empty slot
  always_comb begin
    status_d  = ST_OK;
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_read   = 1'b0;
    if (cmd_q == CMD_FIND) begin
      status_d = ST_OK;
    end else if (32'(pos_q) > 32'(cnt_q)) begin
      status_d = ST_RANGE;
    end else if (cmd_q == CMD_INSERT) begin
      if (32'(cnt_q) >= CAPACITY) begin
        status_d = ST_FULL;
      end else begin
        do_insert = 1'b1;
      end
    end else if ((32'(pos_q) == 32'(cnt_q)) || (32'(pos_q) >= CAPACITY)) begin
      status_d = ST_NO_ELEM;
    end else begin
      do_read   = 1'b1;
      do_remove = (cmd_q == CMD_REMOVE);
    end
  end

  always_comb begin
    req.op    = CH_IDLE;
    req.pos   = IDX_W'(pos_q);
    req.count = cnt_q;
    req.key   = VALUE_WIDTH'(val_q);
    if (exec) begin
      if (do_insert) begin
        req.op = CH_INSERT;
      end else if (do_remove) begin
        req.op = CH_REMOVE;
      end else if (cmd_q == CMD_FIND) begin
        req.op = CH_FIND;
      end
    end
  end

  plel_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rd_data_o   (rd_data),
    .found_o     (found),
    .found_pos_o (found_pos)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (exec && do_insert) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (exec && do_remove) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign data_d = do_read ? VAL_W'(rd_data) : '0;

  // match flags persist between finds; report them only for a find
  assign find_hit = found && (cmd_q == CMD_FIND);
  assign find_pos = find_hit ? found_pos : '0;

  assign result = {LEN_W'(cnt_q), status_q, find_hit, FPOS_W'(find_pos), data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= s_axis_tdata[CMD_W-1:0];
      pos_q <= s_axis_tdata[CMD_W+POS_W-1:CMD_W];
      val_q <= s_axis_tdata[IN_W-1:CMD_W+POS_W];
    end
    if (exec) begin
      data_q   <= data_d;
      status_q <= status_d;
    end
    if (state_q == S_RESP && out_free) begin
      out_data_q <= OUT_TW'(result);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the positional list engine
// A queue of requests feeds the slave stream. Directed requests probe the
// range, empty-slot and not-found cases and value extremes. Fill and drain
// sweeps follow, reaching the full list, with random positions and values.
// A shadow list predicts every result, and the master stream is checked field
// by field. Both sides stall at random, the mix set per phase; the last has none.
// ----------------------------------------------------------------------------
module tb_top;
  import plel_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 360;

  typedef struct packed {
    cmd_e                          cmd;
    logic [POS_W-1:0]              pos;
    logic signed [VALUE_WIDTH-1:0] value;
  } list_req_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] data;
    logic [FPOS_W-1:0]             fpos;
    logic                          found;
    status_e                       status;
    logic [LEN_W-1:0]              len;
  } list_rsp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_TW-1:0]    s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_TW-1:0]   m_axis_tdata;

  list_req_t           req_on_bus = '{cmd: CMD_INSERT, pos: '0, value: '0};
  list_req_t           pending_reqs[$];
  list_rsp_t           rsp_due[$];
  logic                in_taken = 1'b0;
  int                  issued_n = 0;
  int                  taken_n = 0;
  int                  mismatches = 0;
  int                  stall_cycles = 0;
  int                  src_idle_pct = 0;
  int                  snk_idle_pct = 0;

  // shadow copy of the list
  logic [VALUE_WIDTH-1:0] list_mem [CAPACITY];
  int                     list_len = 0;

  logic [VALUE_WIDTH-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                             32'h8000_0000, 32'h0000_0001, 32'h0000_0005,
                                             32'h5555_5555, 32'hAAAA_AAAA};

  positional_list_engine_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  assign s_axis_tdata = {{(IN_TW - IN_W){1'b0}}, req_on_bus.value, req_on_bus.pos,
                         req_on_bus.cmd};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the shadow list and return the result it should give.
  function automatic list_rsp_t apply_request(list_req_t r);
    list_rsp_t rsp;
    rsp = '{data: '0, fpos: '0, found: 1'b0, status: ST_OK, len: '0};
    if (r.cmd == CMD_FIND) begin
      // scan downwards so the lowest match wins
      for (int i = list_len - 1; i >= 0; i--) begin
        if (list_mem[i] == r.value) begin
          rsp.found = 1'b1;
          rsp.fpos  = FPOS_W'(i);
        end
      end
    end else if (int'(r.pos) > list_len) begin
      rsp.status = ST_RANGE;
    end else if (r.cmd == CMD_INSERT) begin
      if (list_len >= CAPACITY) begin
        rsp.status = ST_FULL;
      end else begin
        for (int i = list_len; i > int'(r.pos); i--) list_mem[i] = list_mem[i-1];
        list_mem[r.pos] = r.value;
        list_len++;
      end
    end else if (int'(r.pos) == list_len) begin
      rsp.status = ST_NO_ELEM;
    end else begin
      rsp.data = list_mem[r.pos];
      if (r.cmd == CMD_REMOVE) begin
        for (int i = int'(r.pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
      end
    end
    rsp.len = LEN_W'(list_len);
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send(cmd_e cmd, int pos, logic [VALUE_WIDTH-1:0] value);
    pending_reqs.push_back('{cmd: cmd, pos: POS_W'(pos), value: value});
    issued_n++;
  endtask

  // request driver and result ready, both moved on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          req_on_bus    <= pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    list_rsp_t got;
    list_rsp_t want;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got.data   = m_axis_tdata[31:0];
        got.fpos   = m_axis_tdata[37:32];
        got.found  = m_axis_tdata[38];
        got.status = status_e'(m_axis_tdata[40:39]);
        got.len    = m_axis_tdata[47:41];
        if (rsp_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time,
                   m_axis_tdata);
          mismatches++;
        end else begin
          want = rsp_due.pop_front();
          check_field("data_out", want.data, got.data);
          check_field("found_position", 32'(want.fpos), 32'(got.fpos));
          check_field("found", 32'(want.found), 32'(got.found));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("length_now", 32'(want.len), 32'(got.len));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rsp_due.push_back(apply_request(req_on_bus));
        taken_n++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    cmd_e                   cmd;
    int                     pos;
    int                     roll;
    logic [VALUE_WIDTH-1:0] value;
    bit                     growing;

    growing = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 8;
    snk_idle_pct = 62;

    // empty list: no element, past the end, nothing to find
    send(CMD_GET,    0,   32'h0000_0000);
    send(CMD_REMOVE, 0,   32'h0000_0000);
    send(CMD_INSERT, 1,   32'h1234_5678);
    send(CMD_GET,    127, 32'h0000_0000);
    send(CMD_REMOVE, 64,  32'h0000_0000);
    send(CMD_FIND,   0,   32'h0000_0000);
    // build front, end and middle with extreme values and a duplicate
    send(CMD_INSERT, 0,   32'h7FFF_FFFF);
    send(CMD_INSERT, 0,   32'h8000_0000);
    send(CMD_INSERT, 2,   32'h0000_0000);
    send(CMD_INSERT, 1,   32'hFFFF_FFFF);
    send(CMD_INSERT, 2,   32'hFFFF_FFFF);
    send(CMD_FIND,   0,   32'hFFFF_FFFF);
    send(CMD_FIND,   5,   32'h8000_0000);
    send(CMD_FIND,   0,   32'h0000_3039);
    send(CMD_GET,    4,   32'h0000_0000);
    send(CMD_GET,    5,   32'h0000_0000);
    send(CMD_GET,    6,   32'h0000_0000);
    send(CMD_REMOVE, 1,   32'h0000_0000);
    send(CMD_REMOVE, 0,   32'h0000_0000);
    send(CMD_REMOVE, 2,   32'h0000_0000);
    send(CMD_INSERT, 4,   32'h0BAD_F00D);
    send(CMD_FIND,   127, 32'h7FFF_FFFF);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 62 : 0;
      snk_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 8 : 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold until the shadow list reflects every request sent so far
        wait (taken_n == issued_n);
        if (growing && list_len == CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
        else if (!growing && list_len == 0 && $urandom_range(2) == 0) growing = 1'b1;

        roll = $urandom_range(99);
        if (roll < 12) cmd = CMD_FIND;
        else if (roll < 22) cmd = CMD_GET;
        else if (roll < 30) cmd = growing ? CMD_REMOVE : CMD_INSERT;
        else cmd = growing ? CMD_INSERT : CMD_REMOVE;

        roll = $urandom_range(99);
        if (roll < 40) value = value_pool[$urandom_range(7)];
        else if (roll < 70 && list_len > 0) value = list_mem[$urandom_range(list_len - 1)];
        else value = $urandom();

        roll = $urandom_range(99);
        if (cmd == CMD_FIND) pos = $urandom_range(127);
        else if (roll < 84) begin
          if (cmd == CMD_INSERT) pos = $urandom_range(list_len);
          else pos = (list_len > 0) ? $urandom_range(list_len - 1) : 0;
        end else if (roll < 92) pos = list_len;
        else pos = $urandom_range(127, list_len + 1);

        send(cmd, pos, value);
      end
    end

    wait (taken_n == issued_n);
    wait (rsp_due.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/plel_pkg.sv
rtl/plel_cell.sv
rtl/plel_chain.sv
rtl/positional_list_engine_unit.sv
tb/tb_top.sv
